// File: sv/bfcr_pkg.sv
`timescale 1ns / 1ps

package bfcr_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;

  localparam int AMOUNT_W = 7;
  localparam int FILL_W   = 7;
  localparam int TALLY_W  = 8;
  localparam int STATUS_W = 2;

  typedef enum logic [2:0] {
    MODE_PUSH    = 3'd0,
    MODE_POP     = 3'd1,
    MODE_DROP    = 3'd2,
    MODE_SAVE    = 3'd3,
    MODE_RESTORE = 3'd4,
    MODE_CLEAR   = 3'd5
  } mode_t;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic accept;
    logic pop_load;
    logic pop_last;
    logic pop_fetch;
  } bfcr_cmd_t;

  typedef struct packed {
    logic                slot_free;
    logic                burst;
    logic [AMOUNT_W-1:0] burst_len;
  } bfcr_stat_t;

endpackage

// File: sv/bfcr_ram.sv
`timescale 1ns / 1ps

module bfcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/bfcr_ctrl.sv
`timescale 1ns / 1ps

module bfcr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  bfcr_pkg::bfcr_stat_t stat,
  output bfcr_pkg::bfcr_cmd_t  cmd
);

  import bfcr_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t              state_r, state_nxt;
  logic [AMOUNT_W-1:0] cnt_r, cnt_nxt;
  logic                accept;

  assign in_tready = (state_r == S_IDLE) && stat.slot_free;
  assign accept    = in_tready && in_tvalid;

  always_comb begin
    cmd.accept    = accept;
    cmd.pop_load  = (state_r == S_POP) && stat.slot_free;
    cmd.pop_last  = (cnt_r == AMOUNT_W'(1));
    cmd.pop_fetch = (state_r == S_POP) && stat.slot_free && (cnt_r != AMOUNT_W'(1));
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept && stat.burst) begin
          state_nxt = S_POP;
          cnt_nxt   = stat.burst_len;
        end
      end
      S_POP: begin
        if (stat.slot_free) begin
          cnt_nxt = cnt_r - AMOUNT_W'(1);
          if (cnt_r == AMOUNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: sv/bfcr_dpath.sv
`timescale 1ns / 1ps

module bfcr_dpath #(
  parameter int DEPTH = bfcr_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [bfcr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [bfcr_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bfcr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  input  bfcr_pkg::bfcr_cmd_t             cmd,
  output bfcr_pkg::bfcr_stat_t            stat
);

  import bfcr_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] pos,
                                             input logic [AMOUNT_W-1:0] n);
    logic [7:0] s;
    s = 8'(pos) + 8'(n);
    if (s >= 8'(DEPTH)) begin
      s = s - 8'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  mode_t               mode;
  logic [7:0]          push_byte;
  logic [AMOUNT_W-1:0] amount;
  logic [AMOUNT_W-1:0] occ7;
  logic [AMOUNT_W-1:0] take_n;
  logic                full;

  logic [PW-1:0] wr_pos_r, wr_pos_nxt;
  logic [PW-1:0] rd_pos_r, rd_pos_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [PW-1:0] sv_wr_r, sv_wr_nxt;
  logic [PW-1:0] sv_rd_r, sv_rd_nxt;
  logic [CW-1:0] sv_occ_r, sv_occ_nxt;
  logic [PW-1:0] fetch_r, fetch_nxt;
  logic [AMOUNT_W-1:0] pop_n_r, pop_n_nxt;
  logic [FILL_W-1:0]   pop_fill_r, pop_fill_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [TALLY_W-1:0]  out_tally_r, out_tally_nxt;
  logic [FILL_W-1:0]   out_fill_r, out_fill_nxt;
  logic                load;

  logic          ram_we;
  logic          ram_rd_en;
  logic [PW-1:0] ram_rd_addr;
  logic [7:0]    ram_rd_data;

  assign mode      = mode_t'(in_tuser);
  assign push_byte = in_tdata[7:0];
  assign amount    = in_tdata[14:8];
  assign occ7      = AMOUNT_W'(occ_r);
  assign take_n    = (amount < occ7) ? amount : occ7;
  assign full      = (occ_r == CW'(DEPTH));

  assign stat.slot_free = !out_valid_r || out_tready;
  assign stat.burst     = (mode == MODE_POP) && (occ_r != '0) && (amount != '0);
  assign stat.burst_len = take_n;

  always_comb begin
    wr_pos_nxt     = wr_pos_r;
    rd_pos_nxt     = rd_pos_r;
    occ_nxt        = occ_r;
    sv_wr_nxt      = sv_wr_r;
    sv_rd_nxt      = sv_rd_r;
    sv_occ_nxt     = sv_occ_r;
    fetch_nxt      = fetch_r;
    pop_n_nxt      = pop_n_r;
    pop_fill_nxt   = pop_fill_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_tally_nxt  = out_tally_r;
    out_fill_nxt   = out_fill_r;
    load           = 1'b0;
    ram_we         = 1'b0;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = rd_pos_r;

    if (cmd.accept) begin
      load           = 1'b1;
      out_byte_nxt   = '0;
      out_last_nxt   = 1'b1;
      out_status_nxt = STAT_OK;
      out_tally_nxt  = '0;
      case (mode)
        MODE_PUSH: begin
          if (full) begin
            out_status_nxt = STAT_FULL;
          end else begin
            ram_we     = 1'b1;
            wr_pos_nxt = wrap_add(wr_pos_r, AMOUNT_W'(1));
            occ_nxt    = occ_r + CW'(1);
          end
        end
        MODE_POP: begin
          if (occ_r == '0) begin
            out_status_nxt = STAT_EMPTY;
          end else if (take_n != '0) begin
            load      = 1'b0;
            ram_rd_en = 1'b1;
            fetch_nxt = wrap_add(rd_pos_r, AMOUNT_W'(1));
            pop_n_nxt = take_n;
            if (take_n == occ7) begin
              wr_pos_nxt = '0;
              rd_pos_nxt = '0;
              occ_nxt    = '0;
              sv_wr_nxt  = '0;
              sv_rd_nxt  = '0;
              sv_occ_nxt = '0;
            end else begin
              rd_pos_nxt = wrap_add(rd_pos_r, take_n);
              occ_nxt    = occ_r - CW'(take_n);
            end
            pop_fill_nxt = FILL_W'(occ_nxt);
          end
        end
        MODE_DROP: begin
          if (amount >= occ7) begin
            wr_pos_nxt = '0;
            rd_pos_nxt = '0;
            occ_nxt    = '0;
            sv_wr_nxt  = '0;
            sv_rd_nxt  = '0;
            sv_occ_nxt = '0;
          end else begin
            rd_pos_nxt = wrap_add(rd_pos_r, amount);
            occ_nxt    = occ_r - CW'(amount);
          end
        end
        MODE_SAVE: begin
          out_tally_nxt = TALLY_W'(occ_r) - TALLY_W'(sv_occ_r);
          sv_wr_nxt     = wr_pos_r;
          sv_rd_nxt     = rd_pos_r;
          sv_occ_nxt    = occ_r;
        end
        MODE_RESTORE: begin
          wr_pos_nxt = sv_wr_r;
          rd_pos_nxt = sv_rd_r;
          occ_nxt    = sv_occ_r;
        end
        MODE_CLEAR: begin
          wr_pos_nxt = '0;
          rd_pos_nxt = '0;
          occ_nxt    = '0;
          sv_wr_nxt  = '0;
          sv_rd_nxt  = '0;
          sv_occ_nxt = '0;
        end
        default: begin
        end
      endcase
      out_fill_nxt = FILL_W'(occ_nxt);
    end else if (cmd.pop_load) begin
      load           = 1'b1;
      out_byte_nxt   = ram_rd_data;
      out_last_nxt   = cmd.pop_last;
      out_status_nxt = STAT_OK;
      out_tally_nxt  = TALLY_W'(pop_n_r);
      out_fill_nxt   = pop_fill_r;
      if (cmd.pop_fetch) begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = fetch_r;
        fetch_nxt   = wrap_add(fetch_r, AMOUNT_W'(1));
      end
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r    <= '0;
      rd_pos_r    <= '0;
      occ_r       <= '0;
      sv_wr_r     <= '0;
      sv_rd_r     <= '0;
      sv_occ_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_pos_r    <= wr_pos_nxt;
      rd_pos_r    <= rd_pos_nxt;
      occ_r       <= occ_nxt;
      sv_wr_r     <= sv_wr_nxt;
      sv_rd_r     <= sv_rd_nxt;
      sv_occ_r    <= sv_occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fetch_r      <= fetch_nxt;
    pop_n_r      <= pop_n_nxt;
    pop_fill_r   <= pop_fill_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    out_tally_r  <= out_tally_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  bfcr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (wr_pos_r),
    .wr_data (push_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_fill_r, out_tally_r, out_status_r, out_byte_r};

endmodule

// File: sv/byte_fifo_with_checkpoint_rollback.sv
`timescale 1ns / 1ps
// Output: each input transfer loads its result into the output register; the first
// byte of a pop passes through the registered byte RAM read before that register.
// Throughput: one operation per cycle when the output is taken every cycle; a pop
// holds off the input until its last byte is loaded, one byte a cycle unless stalled.
// Reset: synchronous, active low; empties the FIFO, zeroes the checkpoint and drops
// any pending result. Byte storage is not cleared.
module byte_fifo_with_checkpoint_rollback #(
  parameter int DEPTH = bfcr_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bfcr_pkg::IN_DATA_W-1:0]  in_tdata,   // push_byte[7:0], amount[14:8]
  input  logic [bfcr_pkg::IN_USER_W-1:0]  in_tuser,   // mode[2:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bfcr_pkg::OUT_DATA_W-1:0] out_tdata,  // read_byte[7:0], status[9:8],
                                                      // tally[17:10], fill_level[24:18]
  output logic                            out_tlast
);

  import bfcr_pkg::*;

  bfcr_cmd_t  cmd;
  bfcr_stat_t stat;

  bfcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bfcr_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// File: sv/bfcr_checker.sv
`timescale 1ns / 1ps

module bfcr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [bfcr_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [bfcr_pkg::IN_USER_W-1:0]  in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bfcr_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  import bfcr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output transfer withdrawn");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  a_in_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid || out_tready)
    else $error("input taken with no room for the result");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != MODE_POP) |=> out_tvalid && out_tlast)
    else $error("single-result operation gave no final result");

  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[9:8] == STAT_OK && !in_tready)
    else $error("burst byte with bad status or input open");

endmodule

bind byte_fifo_with_checkpoint_rollback bfcr_checker u_bfcr_checker (.*);
